>>> rtl/core/dqir_pkg.sv
// ----------------------------------------------------------------------------
// Dual quadrature input reporter: shared package
// Types, command codes and the encoder step table used by the core modules.
// ----------------------------------------------------------------------------
package dqir_pkg;

    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QAW    = $clog2(QDEPTH);

    localparam logic [7:0] CMD_INIT_A = 8'h00;
    localparam logic [7:0] CMD_INIT_B = 8'h03;
    localparam logic [7:0] CMD_REPORT = 8'h13;
    localparam logic [7:0] CMD_INIT_C = 8'h16;
    localparam logic [7:0] CMD_INIT_D = 8'h20;
    localparam logic [7:0] CMD_INIT_E = 8'h30;

    localparam logic [7:0] NODE_REPLY_BIT = 8'h80;
    localparam logic [7:0] LEN_INIT       = 8'h01;
    localparam logic [7:0] LEN_REPORT     = 8'h10;
    localparam logic [7:0] REPORT_MARK    = 8'h80;

    localparam logic [4:0] LAST_PLAIN  = 5'd4;
    localparam logic [4:0] LAST_INIT   = 5'd5;
    localparam logic [4:0] LAST_REPORT = 5'd20;

    typedef enum logic [1:0] {
        CLS_PLAIN,
        CLS_INIT,
        CLS_REPORT
    } t_cls;

    typedef struct packed {
        logic [7:0] node_id;
        logic [7:0] msg_type;
        logic [7:0] command;
        logic [7:0] packet_id;
        t_cls       cls;
        logic [9:0] left_cnt;
        logic [9:0] right_cnt;
        logic       test_flag;
        logic       service_flag;
        logic [6:0] key_bits;
    } t_req;

    function automatic logic [15:0] enc_delta(input logic [3:0] idx);
        logic [15:0] d;
        case (idx)
            4'd1, 4'd7, 4'd8, 4'd14:  d = 16'h0001;
            4'd2, 4'd4, 4'd11, 4'd13: d = 16'hFFFF;
            4'd3, 4'd12:              d = 16'h0002;
            4'd6, 4'd9:               d = 16'hFFFE;
            default:                  d = 16'h0000;
        endcase
        return d;
    endfunction

    function automatic logic [4:0] last_index(input t_cls cls);
        logic [4:0] l;
        case (cls)
            CLS_INIT:   l = LAST_INIT;
            CLS_REPORT: l = LAST_REPORT;
            default:    l = LAST_PLAIN;
        endcase
        return l;
    endfunction

endpackage

>>> rtl/core/dqir_front.sv
// ----------------------------------------------------------------------------
// Dual quadrature input reporter: front end
// Accepts items, applies pin ticks to the input state and queues requests.
// ----------------------------------------------------------------------------
module dqir_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic          i_mode,
    input  logic [6:0]    i_key_pins,
    input  logic          i_test_pin,
    input  logic          i_service_pin,
    input  logic [1:0]    i_right_enc_pins,
    input  logic [1:0]    i_left_enc_pins,
    input  logic [7:0]    i_node_id,
    input  logic [7:0]    i_msg_type,
    input  logic [7:0]    i_command,
    input  logic [7:0]    i_packet_id,
    input  logic          i_q_full,
    output logic          o_push,
    output dqir_pkg::t_req o_push_data
);
    import dqir_pkg::*;

    logic [6:0]  r_key_bits;
    logic        r_test;
    logic        r_service;
    logic [1:0]  r_rprev;
    logic [1:0]  r_lprev;
    logic [15:0] r_rcount;
    logic [15:0] r_lcount;
    logic        w_accept;
    logic        w_tick;
    t_cls        w_cls;

    assign o_in_stall = i_mode && i_q_full;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_tick     = w_accept && !i_mode;
    assign o_push     = w_accept && i_mode;

    always_comb begin
        case (i_command)
            CMD_INIT_A, CMD_INIT_B, CMD_INIT_C, CMD_INIT_D, CMD_INIT_E: w_cls = CLS_INIT;
            CMD_REPORT: w_cls = CLS_REPORT;
            default:    w_cls = CLS_PLAIN;
        endcase
    end

    always_comb begin
        o_push_data.node_id      = i_node_id;
        o_push_data.msg_type     = i_msg_type;
        o_push_data.command      = i_command;
        o_push_data.packet_id    = i_packet_id;
        o_push_data.cls          = w_cls;
        o_push_data.left_cnt     = r_lcount[9:0];
        o_push_data.right_cnt    = r_rcount[9:0];
        o_push_data.test_flag    = r_test;
        o_push_data.service_flag = r_service;
        o_push_data.key_bits     = r_key_bits;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_bits <= '0;
            r_test     <= 1'b0;
            r_service  <= 1'b0;
            r_rprev    <= '0;
            r_lprev    <= '0;
            r_rcount   <= '0;
            r_lcount   <= '0;
        end else if (w_tick) begin
            r_key_bits <= ~i_key_pins;
            r_test     <= ~i_test_pin;
            r_service  <= ~i_service_pin;
            r_rprev    <= i_right_enc_pins;
            r_lprev    <= i_left_enc_pins;
            r_rcount   <= r_rcount + enc_delta({i_right_enc_pins, r_rprev});
            r_lcount   <= r_lcount + enc_delta({i_left_enc_pins, r_lprev});
        end
    end

endmodule

>>> rtl/core/dqir_fifo.sv
// ----------------------------------------------------------------------------
// Dual quadrature input reporter: request queue
// Short first-in first-out queue of request snapshots between front and back.
// ----------------------------------------------------------------------------
module dqir_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dqir_pkg::t_req i_push_data,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output dqir_pkg::t_req o_head
);
    import dqir_pkg::*;

    t_req             r_mem [QDEPTH];
    logic [QAW-1:0]   r_wptr;
    logic [QAW-1:0]   r_rptr;
    logic [QAW:0]     r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == QAW'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == QAW'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

endmodule

>>> rtl/core/dqir_back.sv
// ----------------------------------------------------------------------------
// Dual quadrature input reporter: back end
// Holds the gain register, scales the counts and sends each reply byte by byte.
// ----------------------------------------------------------------------------
module dqir_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_wr_en,
    input  logic [15:0]    i_cfg_wr_data,
    input  logic           i_q_empty,
    input  dqir_pkg::t_req i_head,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [7:0]     o_out_byte,
    output logic [4:0]     o_byte_index,
    output logic           o_last
);
    import dqir_pkg::*;

    logic [15:0] r_gain;
    logic        r_busy;
    logic [4:0]  r_idx;
    t_req        r_cur;
    logic [9:0]  r_lv;
    logic [9:0]  r_rv;
    logic        r_ovalid;
    logic [7:0]  r_obyte;
    logic [4:0]  r_oidx;
    logic        r_olast;
    logic        n_busy;
    logic        n_ovalid;
    logic [19:0] w_lprod;
    logic [19:0] w_rprod;
    logic        w_adv;
    logic        w_emit;
    logic        w_is_last;
    logic        w_load;
    logic        w_rep;
    logic [7:0]  w_byte;

    assign w_lprod   = i_head.left_cnt * r_gain[9:0];
    assign w_rprod   = i_head.right_cnt * r_gain[9:0];
    assign w_adv     = !r_ovalid || !i_out_stall;
    assign w_emit    = r_busy && w_adv;
    assign w_is_last = (r_idx == last_index(r_cur.cls));
    assign w_load    = !i_q_empty && (!r_busy || (w_emit && w_is_last));
    assign o_pop     = w_load;
    assign w_rep     = (r_cur.cls == CLS_REPORT);

    always_comb begin
        case (r_idx)
            5'd0: w_byte = r_cur.node_id | NODE_REPLY_BIT;
            5'd1: w_byte = r_cur.msg_type;
            5'd2: w_byte = r_cur.command;
            5'd3: w_byte = r_cur.packet_id;
            5'd4: begin
                case (r_cur.cls)
                    CLS_INIT:   w_byte = LEN_INIT;
                    CLS_REPORT: w_byte = LEN_REPORT;
                    default:    w_byte = 8'h00;
                endcase
            end
            5'd5:  w_byte = w_rep ? r_lv[9:2] : 8'h00;
            5'd6:  w_byte = w_rep ? {r_lv[1:0], r_cur.test_flag, r_cur.service_flag, 4'h0}
                                  : 8'h00;
            5'd7:  w_byte = w_rep ? r_rv[9:2] : 8'h00;
            5'd8:  w_byte = w_rep ? {r_rv[1:0], 6'h00} : 8'h00;
            5'd14: w_byte = w_rep ? {4'h0, r_cur.key_bits[6:3]} : 8'h00;
            5'd16: w_byte = w_rep ? {r_cur.key_bits[4:0], 3'h0} : 8'h00;
            5'd17, 5'd18: w_byte = w_rep ? REPORT_MARK : 8'h00;
            default: w_byte = 8'h00;
        endcase
    end

    always_comb begin
        n_busy   = r_busy;
        n_ovalid = r_ovalid;
        if (w_adv) begin
            n_ovalid = w_emit;
        end
        if (w_load) begin
            n_busy = 1'b1;
        end else if (w_emit && w_is_last) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= 16'h0001;
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_gain <= i_cfg_wr_data;
            end
            r_busy   <= n_busy;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cur <= i_head;
            r_lv  <= w_lprod[9:0];
            r_rv  <= w_rprod[9:0];
            r_idx <= '0;
        end else if (w_emit) begin
            r_idx <= r_idx + 1'b1;
        end
        if (w_emit) begin
            r_obyte <= w_byte;
            r_oidx  <= r_idx;
            r_olast <= w_is_last;
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_out_byte   = r_obyte;
    assign o_byte_index = r_oidx;
    assign o_last       = r_olast;

endmodule

>>> rtl/core/dual_quadrature_input_reporter.sv
// ----------------------------------------------------------------------------
// Dual quadrature input reporter: top level
// Pin ticks update key, button and encoder state; host requests get a reply.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                Payload
//  input     in         i_in_valid / o_in_stall  mode, pins, request bytes
//  output    out        o_out_valid / i_out_stall out_byte, byte_index, last
//  config    in         i_cfg_wr_en              i_cfg_wr_data (volume gain)
//
// A pin tick is taken every cycle and completes in that cycle.
// A request is taken into a two-entry queue; its reply follows at one byte
// per cycle while not stalled (5, 6 or 21 bytes), set by the single byte
// serialiser. The first byte passes the queue, request and output registers.
// Requests stall only while the queue is full; ticks are never stalled.
// Reset is synchronous and active low; the gain resets to one.
module dual_quadrature_input_reporter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_mode,
    input  logic [6:0]  i_key_pins,
    input  logic        i_test_pin,
    input  logic        i_service_pin,
    input  logic [1:0]  i_right_enc_pins,
    input  logic [1:0]  i_left_enc_pins,
    input  logic [7:0]  i_node_id,
    input  logic [7:0]  i_msg_type,
    input  logic [7:0]  i_command,
    input  logic [7:0]  i_packet_id,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic [4:0]  o_byte_index,
    output logic        o_last
);
    import dqir_pkg::*;

    logic w_push;
    t_req w_push_data;
    logic w_pop;
    logic w_full;
    logic w_empty;
    t_req w_head;

    dqir_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_mode           (i_mode),
        .i_key_pins       (i_key_pins),
        .i_test_pin       (i_test_pin),
        .i_service_pin    (i_service_pin),
        .i_right_enc_pins (i_right_enc_pins),
        .i_left_enc_pins  (i_left_enc_pins),
        .i_node_id        (i_node_id),
        .i_msg_type       (i_msg_type),
        .i_command        (i_command),
        .i_packet_id      (i_packet_id),
        .i_q_full         (w_full),
        .o_push           (w_push),
        .o_push_data      (w_push_data)
    );

    dqir_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_full      (w_full),
        .o_empty     (w_empty),
        .o_head      (w_head)
    );

    dqir_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_empty     (w_empty),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_byte_index  (o_byte_index),
        .o_last        (o_last)
    );

endmodule

>>> rtl/core/dqir_checker.sv
// ----------------------------------------------------------------------------
// Dual quadrature input reporter: port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
module dqir_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_mode,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_out_byte,
    input logic [4:0] o_byte_index,
    input logic       o_last
);
    import dqir_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_byte)
            && $stable(o_byte_index) && $stable(o_last))
        else $error("Stalled output transfer changed.");

    a_tick_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> i_mode)
        else $error("A pin tick was stalled.");

    a_first_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_byte_index == 5'd0) |-> o_out_byte[7])
        else $error("Reply header lacks the reply bit.");

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |-> (o_byte_index == LAST_PLAIN)
            || (o_byte_index == LAST_INIT) || (o_byte_index == LAST_REPORT))
        else $error("Reply ended at an impossible length.");

    a_report_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_byte_index == LAST_REPORT) |-> o_last)
        else $error("Report reply did not end at its final byte.");

endmodule

bind dual_quadrature_input_reporter dqir_checker u_dqir_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_mode       (i_mode),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_out_byte   (o_out_byte),
    .o_byte_index (o_byte_index),
    .o_last       (o_last)
);
